FILE: hdl/scbpa_pkg.sv
// ----------------------------------------------------------------------------
// scbpa_pkg
// Shared types, constants and helper functions of the size-class block pool
// allocator.
// ----------------------------------------------------------------------------
package scbpa_pkg;

    localparam int POOL_COUNT        = 14;
    localparam int BLOCKS_PER_POOL   = 1024;
    localparam int FIRST_BLOCK_BYTES = 32;   // power of two
    localparam int WORD_BITS         = 32;   // bitmap memory word
    localparam int ADDR_W            = 48;
    localparam int SIZE_W            = 32;
    localparam int TOTAL_W           = 32;
    localparam int POOL_NUM_W        = 4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_FULL    = 3'd3,
        ST_BADFREE = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_SCAN,
        S_FMAP,
        S_FIDX,
        S_FCHK,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic                operation;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   free_address;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                 status;
        logic [ADDR_W-1:0]          block_address;
        logic [POOL_NUM_W-1:0]      pool_number;
        logic signed [TOTAL_W-1:0]  outside_total;
    } out_word_t;

    // ceil(log2(x)), zero for x <= 1
    function automatic logic [5:0] clog2_32(input logic [SIZE_W-1:0] x);
        logic [SIZE_W-1:0] v;
        logic [5:0]        r;
        v = x - 32'd1;
        r = 6'd0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                r = 6'(i + 1);
            end
        end
        if (x <= 32'd1) begin
            r = 6'd0;
        end
        return r;
    endfunction

    // lowest clear bit of a bitmap word
    function automatic logic [4:0] find_zero(input logic [WORD_BITS-1:0] w);
        logic [4:0] r;
        r = 5'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/scbpa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// scbpa_bitmap_ram
// Used-block bitmap: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scbpa_bitmap_ram #(
    parameter int DEPTH = 448,
    parameter int AW    = 9
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic [scbpa_pkg::WORD_BITS-1:0]  wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic [scbpa_pkg::WORD_BITS-1:0]  rd_data
);

    logic [scbpa_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [scbpa_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/size_class_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator
// Power-of-two size-class block allocator with next-fit bitmap search.
// ----------------------------------------------------------------------------
// One word at a time. The used bitmap sits in a single-port-read memory of
// 32-bit words; the next-fit search reads one word per cycle and picks the
// lowest free bit. An allocate visits one bitmap word in the common case and up
// to BLOCKS_PER_POOL/32 + 1 words on a crowded pool; a free finds the pool and
// block of the address and reads that block's word once; null, outside and full
// results skip the bitmap. The result sits in an output register, so the next
// word is taken while it waits. After reset the bitmap is cleared one word per
// cycle, POOL_COUNT * ceil(BLOCKS_PER_POOL/32) words (448 by default), with s_ready low.
// FIRST_BLOCK_BYTES must be a power of two.
module size_class_block_pool_allocator #(
    parameter int POOL_COUNT        = scbpa_pkg::POOL_COUNT,
    parameter int BLOCKS_PER_POOL   = scbpa_pkg::BLOCKS_PER_POOL,
    parameter int FIRST_BLOCK_BYTES = scbpa_pkg::FIRST_BLOCK_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [scbpa_pkg::ADDR_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scbpa_pkg::in_word_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output scbpa_pkg::out_word_t          m_data
);

    localparam int WB        = scbpa_pkg::WORD_BITS;
    localparam int AW        = scbpa_pkg::ADDR_W;
    localparam int LG_FIRST  = $clog2(FIRST_BLOCK_BYTES);
    localparam int BLK_W     = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
    localparam int CNT_W     = $clog2(BLOCKS_PER_POOL + 1);
    localparam int WPP       = (BLOCKS_PER_POOL + WB - 1) / WB;
    localparam int WPP_W     = (WPP > 1) ? $clog2(WPP) : 1;
    localparam int MEM_DEPTH = POOL_COUNT * WPP;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PIDX_W    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam logic [AW-1:0] POOL_UNIT = AW'(BLOCKS_PER_POOL) * AW'(FIRST_BLOCK_BYTES);

    function automatic logic [AW-1:0] pool_start(input logic [4:0] p);
        return (POOL_UNIT << p) - POOL_UNIT;
    endfunction

    function automatic logic [MEM_AW-1:0] word_addr(input logic [PIDX_W-1:0] p,
                                                    input logic [WPP_W-1:0] w);
        return MEM_AW'(32'(p) * 32'(WPP) + 32'(w));
    endfunction

    scbpa_pkg::fsm_t       state_reg, state_next;
    scbpa_pkg::in_word_t   in_reg, in_next;
    scbpa_pkg::out_word_t  m_data_reg, m_data_next;
    logic                  m_valid_reg, m_valid_next;
    logic [AW-1:0]         base_reg;
    logic [31:0]           outside_reg, outside_next;
    logic [BLK_W-1:0]      ptr_reg [POOL_COUNT];
    logic [BLK_W-1:0]      ptr_next [POOL_COUNT];
    logic [CNT_W-1:0]      cnt_reg [POOL_COUNT];
    logic [CNT_W-1:0]      cnt_next [POOL_COUNT];
    logic [5:0]            psel_reg, psel_next;
    logic [PIDX_W-1:0]     pool_reg, pool_next;
    logic [AW-1:0]         pbase_reg, pbase_next;
    logic [AW-1:0]         off_reg, off_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [WPP_W-1:0]      word_reg, word_next;
    logic                  first_reg, first_next;
    logic [MEM_AW-1:0]     clr_reg, clr_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [AW-1:0]         res_addr_reg, res_addr_next;

    logic                  mem_wr_en, mem_rd_en;
    logic [MEM_AW-1:0]     mem_wr_addr, mem_rd_addr;
    logic [WB-1:0]         mem_wr_data, mem_rd_data;

    logic [AW-1:0]         total;
    assign total = pool_start(5'(POOL_COUNT));

    scbpa_bitmap_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scbpa_pkg::S_CLEAR;
            m_valid_reg <= 1'b0;
            base_reg    <= '0;
            outside_reg <= '0;
            clr_reg     <= '0;
            for (int i = 0; i < POOL_COUNT; i++) begin
                ptr_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            outside_reg <= outside_next;
            clr_reg     <= clr_next;
            ptr_reg     <= ptr_next;
            cnt_reg     <= cnt_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        m_data_reg     <= m_data_next;
        psel_reg       <= psel_next;
        pool_reg       <= pool_next;
        pbase_reg      <= pbase_next;
        off_reg        <= off_next;
        blk_reg        <= blk_next;
        word_reg       <= word_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
    end

    always_comb begin
        logic [31:0]       ptr32, blk32, lim, sum32;
        logic [WB-1:0]     lowmask, invmask, masked;
        logic [4:0]        bit_sel;
        logic [BLK_W-1:0]  b;
        logic [AW-1:0]     rel, braw;
        logic [PIDX_W-1:0] p;
        logic [WPP_W-1:0]  w;

        state_next      = state_reg;
        in_next         = in_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        outside_next    = outside_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        psel_next       = psel_reg;
        pool_next       = pool_reg;
        pbase_next      = pbase_reg;
        off_next        = off_reg;
        blk_next        = blk_reg;
        word_next       = word_reg;
        first_next      = first_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        s_ready         = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = word_addr(pool_reg, word_reg);
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = word_addr(pool_reg, word_reg);
        ptr32   = 32'(ptr_reg[pool_reg]);
        blk32   = 32'(blk_reg);
        lim     = 32'(BLOCKS_PER_POOL) - 32'(word_reg) * 32'(WB);
        lowmask = '0;
        invmask = '0;
        masked  = '0;
        bit_sel = '0;
        b       = '0;
        rel     = '0;
        braw    = '0;
        p       = '0;
        w       = '0;
        sum32   = '0;

        case (state_reg)
            scbpa_pkg::S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                    state_next = scbpa_pkg::S_IDLE;
                end
            end
            scbpa_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = scbpa_pkg::S_DECODE;
                end
            end
            scbpa_pkg::S_DECODE: begin
                res_addr_next = '0;
                pool_next     = '0;
                if (scbpa_pkg::op_t'(in_reg.operation) == scbpa_pkg::OP_ALLOC) begin
                    if (in_reg.request_size < 32'(FIRST_BLOCK_BYTES)) begin
                        psel_next = '0;
                    end else begin
                        psel_next = scbpa_pkg::clog2_32(in_reg.request_size) - 6'(LG_FIRST);
                    end
                    state_next = scbpa_pkg::S_ALLOC;
                end else begin
                    off_next   = in_reg.free_address - base_reg;
                    state_next = scbpa_pkg::S_FMAP;
                end
            end
            scbpa_pkg::S_ALLOC: begin
                p = PIDX_W'(psel_reg);
                ptr32 = 32'(ptr_reg[p]);
                w = WPP_W'(ptr32 / 32'(WB));
                if (in_reg.request_size == '0) begin
                    res_status_next = scbpa_pkg::ST_NULL;
                    state_next      = scbpa_pkg::S_RESP;
                end else if (psel_reg >= 6'(POOL_COUNT)) begin
                    outside_next    = outside_reg + 32'd1;
                    res_status_next = scbpa_pkg::ST_OUTSIDE;
                    state_next      = scbpa_pkg::S_RESP;
                end else if (cnt_reg[p] >= CNT_W'(BLOCKS_PER_POOL)) begin
                    pool_next       = p;
                    res_status_next = scbpa_pkg::ST_FULL;
                    state_next      = scbpa_pkg::S_RESP;
                end else begin
                    pool_next   = p;
                    pbase_next  = base_reg + pool_start(5'(p));
                    word_next   = w;
                    first_next  = 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = word_addr(p, w);
                    state_next  = scbpa_pkg::S_SCAN;
                end
            end
            scbpa_pkg::S_SCAN: begin
                // blocks before the pointer are skipped on the first visit only
                if (first_reg) begin
                    lowmask = (WB'(1) << ptr32[4:0]) - WB'(1);
                end
                if (lim < 32'(WB)) begin
                    invmask = ~((WB'(1) << lim[4:0]) - WB'(1));
                end
                masked = mem_rd_data | lowmask | invmask;
                if (masked != '1) begin
                    bit_sel         = scbpa_pkg::find_zero(masked);
                    sum32           = 32'(word_reg) * 32'(WB) + 32'(bit_sel);
                    b               = BLK_W'(sum32);
                    mem_wr_en       = 1'b1;
                    mem_wr_data     = mem_rd_data | (WB'(1) << bit_sel);
                    ptr_next[pool_reg] = b;
                    cnt_next[pool_reg] = cnt_reg[pool_reg] + 1'b1;
                    res_addr_next   = pbase_reg + (AW'(b) << (LG_FIRST + 32'(pool_reg)));
                    res_status_next = scbpa_pkg::ST_OK;
                    state_next      = scbpa_pkg::S_RESP;
                end else begin
                    if (word_reg == WPP_W'(WPP - 1)) begin
                        w = '0;
                    end else begin
                        w = word_reg + 1'b1;
                    end
                    word_next   = w;
                    first_next  = 1'b0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = word_addr(pool_reg, w);
                end
            end
            scbpa_pkg::S_FMAP: begin
                if (off_reg >= total) begin
                    if (in_reg.free_address == '0) begin
                        res_status_next = scbpa_pkg::ST_NULL;
                    end else begin
                        outside_next    = outside_reg - 32'd1;
                        res_status_next = scbpa_pkg::ST_OUTSIDE;
                    end
                    state_next = scbpa_pkg::S_RESP;
                end else begin
                    for (int q = 1; q < POOL_COUNT; q++) begin
                        if (off_reg >= pool_start(5'(q))) begin
                            p = PIDX_W'(q);
                        end
                    end
                    pool_next  = p;
                    state_next = scbpa_pkg::S_FIDX;
                end
            end
            scbpa_pkg::S_FIDX: begin
                rel  = off_reg - pool_start(5'(pool_reg));
                braw = rel >> (LG_FIRST + 32'(pool_reg));
                if (braw >= AW'(BLOCKS_PER_POOL)) begin
                    b = BLK_W'(BLOCKS_PER_POOL - 1);
                end else begin
                    b = BLK_W'(braw);
                end
                blk32       = 32'(b);
                w           = WPP_W'(blk32 / 32'(WB));
                blk_next    = b;
                word_next   = w;
                mem_rd_en   = 1'b1;
                mem_rd_addr = word_addr(pool_reg, w);
                state_next  = scbpa_pkg::S_FCHK;
            end
            scbpa_pkg::S_FCHK: begin
                if (!mem_rd_data[blk32[4:0]]) begin
                    res_status_next = scbpa_pkg::ST_BADFREE;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = mem_rd_data & ~(WB'(1) << blk32[4:0]);
                    if (cnt_reg[pool_reg] != '0) begin
                        cnt_next[pool_reg] = cnt_reg[pool_reg] - 1'b1;
                    end
                    res_status_next = scbpa_pkg::ST_OK;
                end
                state_next = scbpa_pkg::S_RESP;
            end
            scbpa_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = res_status_reg;
                    m_data_next.block_address = res_addr_reg;
                    m_data_next.pool_number   = scbpa_pkg::POOL_NUM_W'(pool_reg);
                    m_data_next.outside_total = outside_reg;
                    state_next                = scbpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = scbpa_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/scbpa_checker.sv
// ----------------------------------------------------------------------------
// scbpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scbpa_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input scbpa_pkg::out_word_t  m_data
);

    // held result word must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != scbpa_pkg::ST_OK |-> m_data.block_address == '0)
        else $error("address on a failed result");

    a_outside_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == scbpa_pkg::ST_OUTSIDE
                    || m_data.status == scbpa_pkg::ST_NULL) |-> m_data.pool_number == '0)
        else $error("pool number on outside or null result");

    // status code stays within the defined set
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= scbpa_pkg::ST_BADFREE)
        else $error("status code out of range");

    // no new word taken while the block is still busy with one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

endmodule

bind size_class_block_pool_allocator scbpa_checker u_scbpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/tb_scbpa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scbpa_checker
// Watches the request and result channels of the block pool allocator,
// keeps its own copy of the pool state, predicts each result word and
// compares it field by field. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module tb_scbpa_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [47:0]           cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  scbpa_pkg::in_word_t   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  scbpa_pkg::out_word_t  m_data,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int POOLS  = scbpa_pkg::POOL_COUNT;
    localparam int BLOCKS = scbpa_pkg::BLOCKS_PER_POOL;
    localparam int FIRST  = scbpa_pkg::FIRST_BLOCK_BYTES;
    localparam longint POOL_SPAN = longint'(BLOCKS) * FIRST;

    bit                    pool_used [POOLS][BLOCKS];
    int unsigned           fit_ptr [POOLS];
    int unsigned           used_num [POOLS];
    bit [31:0]             outside_cnt;
    bit [47:0]             base_addr;
    scbpa_pkg::out_word_t  expected_words[$];

    assign pending_count = expected_words.size();

    function automatic int unsigned log2_up(bit [31:0] x);
        int unsigned r;
        bit [31:0]   v;
        r = 0;
        if (x <= 1) return 0;
        v = x - 1;
        while (v != 0) begin
            r++;
            v >>= 1;
        end
        return r;
    endfunction

    function automatic bit [47:0] pool_base(int unsigned p);
        return 48'(POOL_SPAN * ((64'd1 << p) - 1));
    endfunction

    function automatic scbpa_pkg::out_word_t predict_word(scbpa_pkg::in_word_t w);
        scbpa_pkg::out_word_t r;
        int unsigned          p, b;
        bit [47:0]            off;
        r = '0;
        r.status = scbpa_pkg::ST_OK;
        if (scbpa_pkg::op_t'(w.operation) == scbpa_pkg::OP_ALLOC) begin
            if (w.request_size == 0) begin
                r.status = scbpa_pkg::ST_NULL;
            end else begin
                p = 0;
                if (w.request_size >= FIRST)
                    p = log2_up(w.request_size) - log2_up(FIRST);
                if (p >= POOLS) begin
                    outside_cnt++;
                    r.status = scbpa_pkg::ST_OUTSIDE;
                end else if (used_num[p] >= BLOCKS) begin
                    r.status = scbpa_pkg::ST_FULL;
                    r.pool_number = 4'(p);
                end else begin
                    b = fit_ptr[p] % BLOCKS;
                    while (pool_used[p][b]) b = (b + 1) % BLOCKS;
                    pool_used[p][b] = 1;
                    fit_ptr[p] = b;
                    used_num[p]++;
                    r.block_address = base_addr + pool_base(p)
                                      + 48'(longint'(b) * (FIRST << p));
                    r.pool_number = 4'(p);
                end
            end
        end else begin
            off = w.free_address - base_addr;
            if (off >= pool_base(POOLS)) begin
                if (w.free_address == 0) begin
                    r.status = scbpa_pkg::ST_NULL;
                end else begin
                    outside_cnt--;
                    r.status = scbpa_pkg::ST_OUTSIDE;
                end
            end else begin
                p = 0;
                while (p + 1 < POOLS && off >= pool_base(p + 1)) p++;
                b = int'((off - pool_base(p)) / (longint'(FIRST) << p));
                if (b >= BLOCKS) b = BLOCKS - 1;
                r.pool_number = 4'(p);
                if (!pool_used[p][b]) begin
                    r.status = scbpa_pkg::ST_BADFREE;
                end else begin
                    pool_used[p][b] = 0;
                    if (used_num[p] > 0) used_num[p]--;
                end
            end
        end
        r.outside_total = outside_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        scbpa_pkg::out_word_t e;
        if (!aresetn) begin
            foreach (pool_used[i, j]) pool_used[i][j] = 0;
            foreach (fit_ptr[i]) begin
                fit_ptr[i] = 0;
                used_num[i] = 0;
            end
            outside_cnt = 0;
            base_addr = 0;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) base_addr = cfg_wr_data;
            if (s_valid && s_ready) expected_words.push_back(predict_word(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    if (m_data.status !== e.status || m_data.block_address !== e.block_address
                        || m_data.pool_number !== e.pool_number
                        || m_data.outside_total !== e.outside_total) begin
                        $display("%0t: mismatch exp st=%0d addr=%h pool=%0d tot=%0d",
                                 $time, e.status, e.block_address, e.pool_number,
                                 e.outside_total);
                        $display("%0t:          act st=%0d addr=%h pool=%0d tot=%0d",
                                 $time, m_data.status, m_data.block_address,
                                 m_data.pool_number, m_data.outside_total);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_size_class_block_pool_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_size_class_block_pool_allocator
// Drives allocate and free words into the pool allocator across several
// region bases, with random idle bursts on both channels; a checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_size_class_block_pool_allocator;

    localparam int CYCLE_LIMIT = 1200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [47:0]           cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    scbpa_pkg::in_word_t   s_data;
    logic                  m_valid;
    logic                  m_ready;
    scbpa_pkg::out_word_t  m_data;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count;
    bit                    calm_phase;
    bit [47:0]             live_addrs[$];

    size_class_block_pool_allocator DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tb_scbpa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        // remember granted addresses so frees hit live blocks
        if (m_valid && m_ready && m_data.status == scbpa_pkg::ST_OK
            && m_data.block_address != 0)
            live_addrs.push_back(m_data.block_address);
    end

    // result-side stall bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge aclk);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(bit op, bit [31:0] sz, bit [47:0] fa);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data.operation <= op;
        s_data.request_size <= sz;
        s_data.free_address <= fa;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_base(bit [47:0] b);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        live_addrs.delete();
    endtask

    function automatic bit [31:0] rand_size();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0) return $urandom;
        if (k == 1) return $urandom_range(0, 40);
        return $urandom_range(1, 32'd1 << $urandom_range(5, 12));
    endfunction

    task automatic random_phase(int n, bit [47:0] b);
        int unsigned k, idx;
        bit [47:0]   a;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 5) begin
                send_word(scbpa_pkg::OP_ALLOC, rand_size(), {$urandom, $urandom});
            end else if (k < 8 && live_addrs.size() != 0) begin
                idx = $urandom_range(0, live_addrs.size() - 1);
                a = live_addrs[idx];
                live_addrs.delete(idx);
                send_word(scbpa_pkg::OP_FREE, $urandom,
                          a + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 31) : 0));
            end else if (k == 8) begin
                send_word(scbpa_pkg::OP_FREE, $urandom,
                          b + 48'($urandom_range(0, 32'h01FF_FFFF)) * 16);
            end else begin
                send_word(scbpa_pkg::OP_FREE, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        calm_phase = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: boundaries, nulls, outside, bad frees
        send_word(scbpa_pkg::OP_ALLOC, 32'd0, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd1, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd32, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd33, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd262144, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd262145, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, '1);
        send_word(scbpa_pkg::OP_FREE, '1, 48'd0);
        send_word(scbpa_pkg::OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd0);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd5);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd40);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd32767);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd1024 * 32 * 16383 - 1);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd1024 * 32 * 16383);
        // fill pool 13 to force pool full and pointer wrap
        for (int i = 0; i < 1026; i++) send_word(scbpa_pkg::OP_ALLOC, 32'd200000, '0);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd1024 * 32 * 8191 + 48'd262144 * 500);
        send_word(scbpa_pkg::OP_ALLOC, 32'd200000, '0);
        send_word(scbpa_pkg::OP_ALLOC, 32'd200000, '0);

        random_phase(40, 48'd0);
        set_base(48'hFFFF_FFFF_FFFF);
        send_word(scbpa_pkg::OP_FREE, '0, 48'd0);
        send_word(scbpa_pkg::OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
        random_phase(30, 48'hFFFF_FFFF_FFFF);
        set_base(48'hFFFF_FFF0_0000);
        random_phase(20, 48'hFFFF_FFF0_0000);
        set_base({$urandom, $urandom});
        calm_phase = 1'b1;
        random_phase(20, 48'd0);
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
